// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
// No dependencies; clocking and reset are passed in by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define TCT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define TCT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tct_pkg.sv =====
// Package for the tunnel connection table: codes, defaults and shared types.
// No dependencies.
package tct_pkg;

	localparam int TABLE_SLOTS_DEF = 64;

	localparam logic [31:0] BASE_VIP_RST = 32'd0;
	localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd3000;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_VIP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd1;

	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_LOOKUP_ADDR = 2'd1;
	localparam logic [1:0] OP_LOOKUP_VIP = 2'd2;
	localparam logic [1:0] OP_SWEEP = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [31:0] real_addr;
		logic [15:0] real_port;
		logic [31:0] client_vip;
		logic [31:0] lookup_vip;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] port;
		logic [31:0] client_vip;
		logic [31:0] last_seen;
	} entry_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] slot;
		logic [31:0] assigned_vip;
		logic [31:0] found_addr;
		logic [15:0] found_port;
		logic [31:0] found_client_vip;
		logic [6:0] active_count;
	} res_t;

endpackage

// ===== design/tct_mem.sv =====
// Slot memory: one entry per slot, one write and one registered read port.
// Depends on tct_pkg (entry_t).
module tct_mem #(
	parameter int TABLE_SLOTS = tct_pkg::TABLE_SLOTS_DEF,
	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [SLOT_W-1:0] waddr,
	input  tct_pkg::entry_t wdata,
	input  logic re,
	input  logic [SLOT_W-1:0] raddr,
	output tct_pkg::entry_t rdata
);

	tct_pkg::entry_t mem [TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/tct_ctrl.sv =====
// Request sequencer: slot scans, read-modify-write of the slot memory,
// valid bits and occupancy count. Depends on tct_pkg and tct_mem.
module tct_ctrl #(
	parameter int TABLE_SLOTS = tct_pkg::TABLE_SLOTS_DEF,
	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  tct_pkg::req_t req,
	input  logic [31:0] base_vip,
	input  logic [31:0] idle_timeout_ms,
	output logic res_valid,
	input  logic res_ready,
	output tct_pkg::res_t res
);

	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TABLE_SLOTS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FREE = 3'd1;
	localparam logic [2:0] S_ASCAN = 3'd2;
	localparam logic [2:0] S_VCHK = 3'd3;
	localparam logic [2:0] S_VRD = 3'd4;
	localparam logic [2:0] S_SWEEP = 3'd5;
	localparam logic [2:0] S_PUSH = 3'd6;

	logic [2:0] state_q;
	logic [CNT_W-1:0] scan_q;
	logic rd_vld_s1;
	logic [SLOT_W-1:0] rd_idx_s1;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [CNT_W-1:0] occ_q;
	tct_pkg::req_t req_q;
	tct_pkg::res_t res_q;

	logic mem_we, mem_re;
	logic [SLOT_W-1:0] mem_waddr, mem_raddr;
	tct_pkg::entry_t mem_wdata, mem_rdata;

	logic [SLOT_W-1:0] scan_idx;
	logic scan_end, free_hit, vip_hit, rd_live, addr_hit, expire;
	logic [31:0] vip_diff, age, scan_vip, rd_vip;

	tct_mem #(.TABLE_SLOTS(TABLE_SLOTS)) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	function automatic tct_pkg::res_t miss_res(input logic [1:0] st);
		tct_pkg::res_t r;
		r = '0;
		r.status = st;
		return r;
	endfunction

	always_comb begin
		scan_idx = scan_q[SLOT_W-1:0];
		scan_end = (scan_q == SLOTS_C);
		free_hit = (state_q == S_FREE) && !scan_end && !valid_q[scan_idx];
		vip_diff = req_q.lookup_vip - base_vip - 32'd1;
		vip_hit = (vip_diff < 32'(TABLE_SLOTS)) && valid_q[vip_diff[SLOT_W-1:0]];
		rd_live = rd_vld_s1 && valid_q[rd_idx_s1];
		addr_hit = (state_q == S_ASCAN) && rd_live && (mem_rdata.addr == req_q.real_addr);
		age = req_q.now_ms - mem_rdata.last_seen;
		expire = (state_q == S_SWEEP) && rd_live && (age > idle_timeout_ms);
		scan_vip = base_vip + 32'(scan_idx) + 32'd1;
		rd_vip = base_vip + 32'(rd_idx_s1) + 32'd1;
	end

	// memory port control; a refresh writes back the entry read in the cycle before
	always_comb begin
		mem_re = (((state_q == S_ASCAN) && !addr_hit) || (state_q == S_SWEEP)) && !scan_end
			|| ((state_q == S_VCHK) && vip_hit);
		mem_raddr = (state_q == S_VCHK) ? vip_diff[SLOT_W-1:0] : scan_idx;
		mem_we = free_hit || addr_hit;
		mem_waddr = (state_q == S_FREE) ? scan_idx : rd_idx_s1;
		if (state_q == S_FREE) begin
			mem_wdata.addr = req_q.real_addr;
			mem_wdata.port = req_q.real_port;
			mem_wdata.client_vip = req_q.client_vip;
			mem_wdata.last_seen = req_q.now_ms;
		end else begin
			mem_wdata = mem_rdata;
			mem_wdata.last_seen = req_q.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q <= '0;
			rd_vld_s1 <= 1'b0;
			valid_q <= '0;
			occ_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					scan_q <= '0;
					rd_vld_s1 <= 1'b0;
					if (in_valid) begin
						unique case (req.op)
							tct_pkg::OP_REGISTER: state_q <= S_FREE;
							tct_pkg::OP_LOOKUP_ADDR: state_q <= S_ASCAN;
							tct_pkg::OP_LOOKUP_VIP: state_q <= S_VCHK;
							tct_pkg::OP_SWEEP: state_q <= S_SWEEP;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_FREE: begin
					if (scan_end) begin
						state_q <= S_PUSH;
					end else if (free_hit) begin
						valid_q[scan_idx] <= 1'b1;
						occ_q <= occ_q + 1'b1;
						state_q <= S_PUSH;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_ASCAN, S_SWEEP: begin
					rd_vld_s1 <= mem_re;
					if (mem_re) begin
						scan_q <= scan_q + 1'b1;
					end
					if (expire) begin
						valid_q[rd_idx_s1] <= 1'b0;
						occ_q <= occ_q - 1'b1;
					end
					if (addr_hit || (scan_end && !rd_vld_s1)) begin
						state_q <= S_PUSH;
					end
				end
				S_VCHK: state_q <= vip_hit ? S_VRD : S_PUSH;
				S_VRD: state_q <= S_PUSH;
				S_PUSH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= req;
		end
		if (state_q == S_VCHK) begin
			rd_idx_s1 <= vip_diff[SLOT_W-1:0];
		end else begin
			rd_idx_s1 <= scan_idx;
		end
		unique case (state_q)
			S_FREE: begin
				if (scan_end) begin
					res_q <= miss_res(tct_pkg::ST_FULL);
				end else begin
					res_q.status <= tct_pkg::ST_OK;
					res_q.slot <= 6'(scan_idx);
					res_q.assigned_vip <= scan_vip;
					res_q.found_addr <= req_q.real_addr;
					res_q.found_port <= req_q.real_port;
					res_q.found_client_vip <= req_q.client_vip;
				end
			end
			S_ASCAN, S_VRD: begin
				if (addr_hit || state_q == S_VRD) begin
					res_q.status <= tct_pkg::ST_OK;
					res_q.slot <= 6'(rd_idx_s1);
					res_q.assigned_vip <= rd_vip;
					res_q.found_addr <= mem_rdata.addr;
					res_q.found_port <= mem_rdata.port;
					res_q.found_client_vip <= mem_rdata.client_vip;
				end else begin
					res_q <= miss_res(tct_pkg::ST_MISS);
				end
			end
			S_VCHK: res_q <= miss_res(tct_pkg::ST_MISS);
			S_SWEEP: res_q <= miss_res(tct_pkg::ST_OK);
			default: res_q <= res_q;
		endcase
	end

	always_comb begin
		res = res_q;
		res.active_count = 7'(occ_q);
	end

	assign in_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_PUSH);

endmodule

// ===== design/tunnel_connection_table.sv =====
// Top level of the tunnel connection table: stream ports, configuration
// registers, output register. Depends on tct_pkg and tct_ctrl.
//
// channel  | valid / ready               | payload
// ---------+-----------------------------+------------------------------
// request  | s_axis_tvalid/s_axis_tready | s_axis_tuser op, s_axis_tdata
// result   | m_axis_tvalid/m_axis_tready | m_axis_tuser status, tdata
// config   | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// One request at a time. Register walks the valid bits until it finds a free
// slot. Address lookup and sweep read the slot memory one entry a cycle; an
// address lookup stops at its first hit. Virtual IP lookup checks the valid bit
// of its slot and reads the slot memory only on a hit.
// Valid bits are flops cleared by reset; no memory clearing pass.
// A finished result waits in the output register while the next request runs.
module tunnel_connection_table #(
	parameter int TABLE_SLOTS = tct_pkg::TABLE_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [31:0] real_addr, [47:32] real_port, [79:48] client_vip,
	// [111:80] lookup_vip, [143:112] now_ms
	input  logic [143:0] s_axis_tdata,
	// [1:0] op
	input  logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [5:0] slot, [37:6] assigned_vip, [69:38] found_addr, [85:70] found_port,
	// [117:86] found_client_vip, [124:118] active_count, [127:125] zero
	output logic [127:0] m_axis_tdata,
	// [1:0] status
	output logic [1:0] m_axis_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tct_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] base_vip_q, idle_timeout_q;
	tct_pkg::req_t req;
	tct_pkg::res_t res, out_q;
	logic res_valid, res_ready, out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_vip_q <= tct_pkg::BASE_VIP_RST;
			idle_timeout_q <= tct_pkg::IDLE_TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tct_pkg::CFG_BASE_VIP: base_vip_q <= cfg_data;
				tct_pkg::CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		req.op = s_axis_tuser;
		req.real_addr = s_axis_tdata[31:0];
		req.real_port = s_axis_tdata[47:32];
		req.client_vip = s_axis_tdata[79:48];
		req.lookup_vip = s_axis_tdata[111:80];
		req.now_ms = s_axis_tdata[143:112];
	end

	tct_ctrl #(.TABLE_SLOTS(TABLE_SLOTS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.req(req),
		.base_vip(base_vip_q),
		.idle_timeout_ms(idle_timeout_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_q.status;
	assign m_axis_tdata = {3'b000, out_q.active_count, out_q.found_client_vip,
		out_q.found_port, out_q.found_addr, out_q.assigned_vip, out_q.slot};

endmodule

// ===== design/tct_checker.sv =====
// Port-level checker for the tunnel connection table, bound to the top level.
// Depends on assert_macros.svh and tct_pkg.
`include "assert_macros.svh"

module tct_checker #(
	parameter int TABLE_SLOTS = tct_pkg::TABLE_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser
);

	`TCT_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	`TCT_ASSERT_NXT(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready,
		!s_axis_tready, "request taken while another is in progress")

	`TCT_ASSERT_IMP(a_fail_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser != tct_pkg::ST_OK,
		m_axis_tdata[117:0] == 118'd0, "failed request carries slot data")

	`TCT_ASSERT_IMP(a_full_count, clk, arst_n, m_axis_tvalid && m_axis_tuser == tct_pkg::ST_FULL,
		m_axis_tdata[124:118] == 7'(TABLE_SLOTS), "table full with free slots")

endmodule

bind tunnel_connection_table tct_checker #(.TABLE_SLOTS(TABLE_SLOTS)) u_tct_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

// ===== bench/tunnel_connection_table_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the tunnel connection table: watches the request, result and
// config channels and keeps its own copy of the slot table to predict each result.
// Depends on tct_pkg.
module tunnel_connection_table_checker
	import tct_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	// [31:0] real_addr, [47:32] real_port, [79:48] client_vip,
	// [111:80] lookup_vip, [143:112] now_ms
	input  logic [143:0] s_axis_tdata,
	// [1:0] op
	input  logic [1:0] s_axis_tuser,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [5:0] slot, [37:6] assigned_vip, [69:38] found_addr, [85:70] found_port,
	// [117:86] found_client_vip, [124:118] active_count
	input  logic [127:0] m_axis_tdata,
	// [1:0] status
	input  logic [1:0] m_axis_tuser,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int pending,
	output int mismatch_count,
	output int checked_count,
	output int full_count,
	output int expired_count
);

	logic in_use [TABLE_SLOTS];
	entry_t slots [TABLE_SLOTS];
	int unsigned live;
	logic [31:0] base_vip_q;
	logic [31:0] timeout_q;
	res_t answers_due [$];
	req_t seen_req;
	res_t want;
	res_t got;
	int mism = 0;
	int checked = 0;
	int full_seen = 0;
	int expired = 0;

	function automatic res_t slot_report(int unsigned i);
		res_t r;
		r = '0;
		r.status = ST_OK;
		r.slot = i[5:0];
		r.assigned_vip = base_vip_q + i + 32'd1;
		r.found_addr = slots[i].addr;
		r.found_port = slots[i].port;
		r.found_client_vip = slots[i].client_vip;
		return r;
	endfunction

	function automatic res_t table_answer(req_t rq);
		res_t r;
		logic [31:0] idx;
		logic [31:0] age;
		logic done;
		r = '0;
		done = 1'b0;
		case (rq.op)
		OP_REGISTER: begin
			r.status = ST_FULL;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				if (!done && !in_use[i]) begin
					in_use[i] = 1'b1;
					slots[i].addr = rq.real_addr;
					slots[i].port = rq.real_port;
					slots[i].client_vip = rq.client_vip;
					slots[i].last_seen = rq.now_ms;
					live++;
					r = slot_report(i);
					done = 1'b1;
				end
			end
			if (!done)
				full_seen++;
		end
		OP_LOOKUP_ADDR: begin
			r.status = ST_MISS;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				if (!done && in_use[i] && slots[i].addr == rq.real_addr) begin
					slots[i].last_seen = rq.now_ms;
					r = slot_report(i);
					done = 1'b1;
				end
			end
		end
		OP_LOOKUP_VIP: begin
			idx = rq.lookup_vip - base_vip_q - 32'd1;
			if (idx < TABLE_SLOTS && in_use[idx])
				r = slot_report(idx);
			else
				r.status = ST_MISS;
		end
		OP_SWEEP: begin
			r.status = ST_OK;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				age = rq.now_ms - slots[i].last_seen;
				if (in_use[i] && age > timeout_q) begin
					in_use[i] = 1'b0;
					if (live > 0)
						live--;
					expired++;
				end
			end
		end
		endcase
		r.active_count = live[6:0];
		return r;
	endfunction

	task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mism++;
			if (mism <= 10)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++)
				in_use[i] = 1'b0;
			live = 0;
			base_vip_q = BASE_VIP_RST;
			timeout_q = IDLE_TIMEOUT_RST;
			answers_due.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_BASE_VIP: base_vip_q = cfg_data;
				CFG_IDLE_TIMEOUT: timeout_q = cfg_data;
				default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '0;
				got.status = m_axis_tuser;
				got.slot = m_axis_tdata[5:0];
				got.assigned_vip = m_axis_tdata[37:6];
				got.found_addr = m_axis_tdata[69:38];
				got.found_port = m_axis_tdata[85:70];
				got.found_client_vip = m_axis_tdata[117:86];
				got.active_count = m_axis_tdata[124:118];
				if (answers_due.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("%0t: result transfer with nothing outstanding", $time);
				end else begin
					want = answers_due.pop_front();
					check_field("status", want.status, got.status);
					check_field("slot", want.slot, got.slot);
					check_field("assigned_vip", want.assigned_vip, got.assigned_vip);
					check_field("found_addr", want.found_addr, got.found_addr);
					check_field("found_port", want.found_port, got.found_port);
					check_field("found_client_vip", want.found_client_vip,
						got.found_client_vip);
					check_field("active_count", want.active_count, got.active_count);
					checked++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				seen_req.op = s_axis_tuser;
				seen_req.real_addr = s_axis_tdata[31:0];
				seen_req.real_port = s_axis_tdata[47:32];
				seen_req.client_vip = s_axis_tdata[79:48];
				seen_req.lookup_vip = s_axis_tdata[111:80];
				seen_req.now_ms = s_axis_tdata[143:112];
				answers_due.push_back(table_answer(seen_req));
			end
			pending <= answers_due.size();
		end
		mismatch_count <= mism;
		checked_count <= checked;
		full_count <= full_seen;
		expired_count <= expired;
	end

endmodule

// ===== bench/tunnel_connection_table_test.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the tunnel connection table: directed requests, then
// phases of random traffic under several register settings. Depends on tct_pkg,
// tunnel_connection_table and tunnel_connection_table_checker.
module tunnel_connection_table_test;
	import tct_pkg::*;

	localparam int TABLE_SLOTS = TABLE_SLOTS_DEF;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 120;
	localparam int POOL = 12;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 5000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef enum int {FILL, MIXED, CHURN} load_mix_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [143:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	int pending;
	int mismatch_count;
	int checked_count;
	int full_count;
	int expired_count;

	logic tx_calm = 1'b0;
	logic rx_calm = 1'b0;
	logic hold_rx = 1'b0;
	logic [31:0] now_t = 32'd0;
	logic [31:0] cur_base = BASE_VIP_RST;
	logic [31:0] addr_pool [POOL];
	int sent = 0;
	int writes = 0;
	int quiet = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	tunnel_connection_table #(.TABLE_SLOTS(TABLE_SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tunnel_connection_table_checker #(.TABLE_SLOTS(TABLE_SLOTS)) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pending(pending),
		.mismatch_count(mismatch_count),
		.checked_count(checked_count),
		.full_count(full_count),
		.expired_count(expired_count)
	);

	// valid stays high across back-to-back transfers; lowered only for a gap
	task automatic send_req(logic [1:0] op, logic [31:0] addr, logic [15:0] port,
			logic [31:0] cvip, logic [31:0] lvip, logic [31:0] now);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {now, lvip, cvip, port, addr};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		writes++;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_addr();
		if ($urandom_range(0, 9) < 8)
			return addr_pool[$urandom_range(0, POOL - 1)];
		return $urandom;
	endfunction

	task automatic random_item(load_mix_t mix);
		int roll;
		logic [1:0] op;
		logic [31:0] now;
		logic [31:0] lvip;
		roll = $urandom_range(0, 99);
		case (mix)
		FILL: begin
			op = roll < 60 ? OP_REGISTER : roll < 75 ? OP_LOOKUP_ADDR :
				roll < 95 ? OP_LOOKUP_VIP : OP_SWEEP;
			now_t += $urandom_range(0, 20);
		end
		MIXED: begin
			op = roll < 30 ? OP_REGISTER : roll < 55 ? OP_LOOKUP_ADDR :
				roll < 80 ? OP_LOOKUP_VIP : OP_SWEEP;
			now_t += $urandom_range(0, 400);
		end
		default: begin
			op = roll < 25 ? OP_REGISTER : roll < 45 ? OP_LOOKUP_ADDR :
				roll < 65 ? OP_LOOKUP_VIP : OP_SWEEP;
			now_t += $urandom_range(0, 1500);
		end
		endcase
		now = ($urandom_range(0, 31) == 0) ? $urandom : now_t;
		lvip = ($urandom_range(0, 9) < 8) ? cur_base + $urandom_range(0, TABLE_SLOTS + 2)
			: $urandom;
		send_req(op, pick_addr(), 16'($urandom_range(0, 16'hFFFF)), $urandom, lvip, now);
	endtask

	// result side: random stalls, calm stretches, and a long hold on request
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end else begin
				stall = rx_calm ? 0 : $urandom_range(0, 4);
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		logic [31:0] nb;
		logic [31:0] nt;
		load_mix_t mix;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_REGISTER;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_BASE_VIP;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, field extremes, duplicates, index edges, aging edges
		send_req(OP_LOOKUP_ADDR, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0);
		send_req(OP_LOOKUP_VIP, 32'd0, 16'd0, 32'd0, 32'd1, 32'd0);
		send_req(OP_SWEEP, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0);
		send_req(OP_REGISTER, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0);
		send_req(OP_REGISTER, '1, '1, '1, '1, 32'd100);
		send_req(OP_REGISTER, '1, 16'h1234, 32'd5, 32'd0, 32'd200);
		send_req(OP_LOOKUP_ADDR, '1, 16'd0, 32'd0, 32'd0, 32'd3000);
		send_req(OP_LOOKUP_VIP, 32'd0, 16'd0, 32'd0, 32'd1, 32'd3000);
		send_req(OP_LOOKUP_VIP, 32'd0, 16'd0, 32'd0, 32'd0, 32'd3000);
		send_req(OP_LOOKUP_VIP, 32'd0, 16'd0, 32'd0, 32'd64, 32'd3000);
		send_req(OP_LOOKUP_VIP, 32'd0, 16'd0, 32'd0, 32'd65, 32'd3000);
		send_req(OP_LOOKUP_VIP, 32'd0, 16'd0, 32'd0, '1, 32'd3000);
		send_req(OP_SWEEP, 32'd0, 16'd0, 32'd0, 32'd0, 32'd3150);
		send_req(OP_SWEEP, 32'd0, 16'd0, 32'd0, 32'd0, 32'd3200);
		send_req(OP_SWEEP, 32'd0, 16'd0, 32'd0, 32'd0, 32'd3201);
		send_req(OP_REGISTER, 32'h0A00_0001, 16'd4500, 32'h0A08_0002, 32'd0, 32'd3300);
		send_req(OP_LOOKUP_ADDR, 32'h0A00_0001, 16'd0, 32'd0, 32'd0, 32'd3400);
		send_req(OP_LOOKUP_VIP, 32'd0, 16'd0, 32'd0, 32'd3, 32'd3400);
		send_req(OP_LOOKUP_ADDR, 32'd0, 16'd0, 32'd0, 32'd0, 32'd3400);
		send_req(OP_SWEEP, '1, '1, '1, '1, '1);
		send_req(OP_LOOKUP_ADDR, '1, '1, '1, '1, '1);
		s_axis_tvalid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
			0: begin nb = '1; nt = '1; mix = FILL; end
			1: begin nb = $urandom; nt = IDLE_TIMEOUT_RST; mix = MIXED; end
			2: begin nb = 32'hFFFF_FFC0; nt = 32'd0; mix = CHURN; end
			3: begin nb = 32'd0; nt = 32'd1000; mix = MIXED; end
			4: begin nb = $urandom; nt = '1; mix = FILL; end
			5: begin nb = 32'h0A08_0000; nt = $urandom_range(0, 5000); mix = CHURN; end
			6: begin nb = $urandom; nt = IDLE_TIMEOUT_RST; mix = MIXED; end
			7: begin nb = $urandom; nt = $urandom; mix = MIXED; end
			8: begin nb = 32'd0; nt = 32'd0; mix = FILL; end
			default: begin nb = '1; nt = 32'd2000; mix = CHURN; end
			endcase
			write_reg(CFG_BASE_VIP, nb);
			write_reg(CFG_IDLE_TIMEOUT, nt);
			// indexes past the register list must be ignored
			if (p == 3) begin
				write_reg(CFG_SPARE_A, $urandom);
				write_reg(CFG_SPARE_B, $urandom);
			end
			cur_base = nb;
			now_t = (p % 4 == 2) ? 32'hFFFF_F000 : $urandom;
			addr_pool[0] = 32'd0;
			addr_pool[1] = '1;
			for (int k = 2; k < POOL; k++)
				addr_pool[k] = $urandom;
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ((p == 1 || p == 5) && n == 20)
					hold_rx = 1'b1;
				random_item(mix);
			end
			s_axis_tvalid <= 1'b0;
		end

		wait_drained();
		repeat (TABLE_SLOTS + 8) @(posedge clk);
		$display("Sent %0d requests over %0d register writes; %0d results compared.",
			sent, writes, checked_count);
		$display("Table-full answers: %0d, slots aged out by sweeps: %0d.",
			full_count, expired_count);
		if (mismatch_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
